// ===== sv/pis_pkg.sv =====
// Shared types and constants for the page idleness scorer.
`timescale 1ns / 1ps
package pis_pkg;

  typedef enum logic [1:0] {
    ST_SCORED = 2'd0,
    ST_ABSENT = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  // Register index as given by paddr[3] (8-byte register stride).
  typedef enum logic {
    REG_PAGES_IN_USE    = 1'b0,
    REG_IDLE_MAP_FRAMES = 1'b1
  } reg_sel_t;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [9:0]  SCORE_CAP     = 10'd1000;
  localparam logic [4:0]  GRAD_TOP      = 5'd20;
  localparam logic [3:0]  BOOST_DIST    = 4'd8;
  localparam logic [3:0]  DIST_SAT      = 4'd9;
  localparam logic [9:0]  BOOST_AMOUNT  = 10'd300;
  localparam logic [9:0]  HUGE_DISCOUNT = 10'd350;
  localparam logic [9:0]  IDLE_BONUS    = 10'd400;
  localparam logic [16:0] HUGE_STEP     = 17'd512;
  localparam logic [9:0]  HIST_INIT     = 10'd980;
  localparam logic [15:0] DIV5_MUL      = 16'd52429;  // ceil(2^18 / 5)
  localparam int unsigned DIV5_SHIFT    = 18;

  localparam logic [16:0] PAGES_IN_USE_RST = 17'd65536;
  localparam logic [32:0] IDLE_FRAMES_RST  = 33'd8388608;

  // One classified request, as handed from the front end to the back end.
  typedef struct packed {
    logic [15:0] page_index;
    status_t     status;
    logic [4:0]  gradient;
    logic        boost;
    logic        idle;
    logic        huge;
    logic [16:0] next_page;
    logic        pass_done;
  } job_t;

endpackage

// ===== sv/page_idleness_scorer.sv =====
// Top level of the page idleness scorer: stream ports, register port, assertions.
`timescale 1ns / 1ps
// Scores one page-table entry per clock while m_tready is high and no
// clearing pass runs. A front end keeps the pass state (gradient, busy
// distance, page counter) and classifies each request; a four-entry queue
// feeds a back end that reads the per-page history word, computes the new
// score, writes the history back and holds the result in an output register.
// The history memory has one read and one write port, with a bypass when a
// request hits the entry written in the same cycle. After reset a clearing
// pass writes the reset history value into every entry, one per cycle, so
// s_tready stays low until that pass ends; register writes are taken during
// that time.
module page_idleness_scorer #(
  parameter int unsigned PAGES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // present, frame_number[54:0], idle_bit, huge, zero fill
  input  logic        s_tuser,   // first_of_pass
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // page_index[15:0], score[9:0], status[1:0], next_page[16:0]
  output logic        m_tlast,   // pass_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import pis_pkg::*;

  localparam int unsigned IDX_W = $clog2(PAGES);
  localparam int unsigned JW    = $bits(job_t) + IDX_W;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [16:0] pages_in_use;
  logic [32:0] idle_map_frames;
  reg_sel_t    reg_sel;

  logic             accept, q_full, head_valid, pop, clearing;
  job_t             job, head_job;
  logic [IDX_W-1:0] job_idx, head_idx;
  logic [JW-1:0]    head_data;
  logic [CNT_W-1:0] q_count;

  logic [15:0] out_page_index;
  logic [9:0]  out_score;
  status_t     out_status;
  logic [16:0] out_next_page;

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[3]);

  always_comb begin
    case (reg_sel)
      REG_PAGES_IN_USE:    prdata = {47'd0, pages_in_use};
      REG_IDLE_MAP_FRAMES: prdata = {31'd0, idle_map_frames};
      default:             prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use    <= PAGES_IN_USE_RST;
      idle_map_frames <= IDLE_FRAMES_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_PAGES_IN_USE:    pages_in_use    <= pwdata[16:0];
        REG_IDLE_MAP_FRAMES: idle_map_frames <= pwdata[32:0];
        default:             pages_in_use    <= pages_in_use;
      endcase
    end
  end

  assign s_tready = !q_full && !clearing;
  assign accept   = s_tvalid && s_tready;

  pis_front #(.IDX_W(IDX_W), .PAGES(PAGES)) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .first_of_pass   (s_tuser),
    .present         (s_tdata[0]),
    .frame_number    (s_tdata[55:1]),
    .idle_bit        (s_tdata[56]),
    .huge            (s_tdata[57]),
    .pages_in_use    (pages_in_use),
    .idle_map_frames (idle_map_frames),
    .job             (job),
    .job_idx         (job_idx)
  );

  pis_queue #(.W(JW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  ({job_idx, job}),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .count      (q_count)
  );

  assign head_job = job_t'(head_data[$bits(job_t)-1:0]);
  assign head_idx = head_data[JW-1 -: IDX_W];

  pis_back #(.IDX_W(IDX_W), .PAGES(PAGES)) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .head_idx       (head_idx),
    .pop            (pop),
    .clearing       (clearing),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_page_index (out_page_index),
    .out_score      (out_score),
    .out_status     (out_status),
    .out_next_page  (out_next_page),
    .out_pass_done  (m_tlast)
  );

  assign m_tdata = {3'd0, out_next_page, out_status, out_score, out_page_index};

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("request accepted during history clearing pass");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("request queue overflow");

  a_score_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_score <= SCORE_CAP)
    else $error("score above cap");

  a_unscored_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != ST_SCORED) |-> out_score == 10'd0)
    else $error("nonzero score on unscored page");

endmodule

// ===== sv/pis_front.sv =====
// Front end: pass state, gradient, busy distance, page counter and classification.
`timescale 1ns / 1ps
module pis_front #(
  parameter int unsigned IDX_W = 16,
  parameter int unsigned PAGES = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                first_of_pass,
  input  logic                present,
  input  logic [54:0]         frame_number,
  input  logic                idle_bit,
  input  logic                huge,
  input  logic [16:0]         pages_in_use,
  input  logic [32:0]         idle_map_frames,
  output pis_pkg::job_t       job,
  output logic [IDX_W-1:0]    job_idx
);
  import pis_pkg::*;

  localparam logic [IDX_W:0] PAGES_W = (IDX_W + 1)'(PAGES);

  logic [4:0]       gradient, gradient_next;
  logic             falling, falling_next;
  logic [3:0]       busy_distance, busy_distance_next;
  logic [16:0]      page_counter;
  logic [IDX_W-1:0] idx, idx_next;

  logic [4:0]       g_in, g_step;
  logic             f_in;
  logic [3:0]       bd_in, bd_mid;
  logic [16:0]      pc_in, inc;
  logic [17:0]      pc_sum;
  logic [IDX_W-1:0] idx_in;
  logic [IDX_W:0]   idx_sum;
  status_t          status;
  logic             scored;

  always_comb begin
    g_in   = first_of_pass ? 5'd0 : gradient;
    f_in   = first_of_pass ? 1'b0 : falling;
    bd_in  = first_of_pass ? DIST_SAT : busy_distance;
    pc_in  = first_of_pass ? 17'd0 : page_counter;
    idx_in = first_of_pass ? '0 : idx;

    if (!f_in) begin
      g_step = g_in + 5'd1;
    end else begin
      g_step = (g_in != 5'd0) ? g_in - 5'd1 : 5'd0;
    end
    gradient_next = g_step;
    falling_next  = f_in;
    if (g_step >= GRAD_TOP) begin
      gradient_next = GRAD_TOP;
      falling_next  = 1'b1;
    end else if (g_step == 5'd0) begin
      falling_next = 1'b0;
    end

    if (!present || frame_number == 55'd0) begin
      status = ST_ABSENT;
    end else if (frame_number >= {22'd0, idle_map_frames}) begin
      status = ST_RANGE;
    end else begin
      status = ST_SCORED;
    end
    scored = (status == ST_SCORED);

    bd_mid = (scored && !idle_bit) ? 4'd0 : bd_in;
    busy_distance_next = (bd_mid < DIST_SAT) ? bd_mid + 4'd1 : bd_mid;

    inc    = (scored && huge) ? HUGE_STEP : 17'd1;
    pc_sum = {1'b0, pc_in} + {1'b0, inc};

    // Track page_counter modulo PAGES; after a 17-bit wrap the counter is below 512.
    idx_sum = {1'b0, idx_in} + (IDX_W + 1)'(inc);
    if (pc_sum[17]) begin
      idx_next = IDX_W'(pc_sum[16:0]);
    end else if (idx_sum >= PAGES_W) begin
      idx_next = IDX_W'(idx_sum - PAGES_W);
    end else begin
      idx_next = idx_sum[IDX_W-1:0];
    end

    job.page_index = pc_in[15:0];
    job.status     = status;
    job.gradient   = gradient_next;
    job.boost      = (bd_in < BOOST_DIST);
    job.idle       = idle_bit;
    job.huge       = huge;
    job.next_page  = pc_sum[16:0];
    job.pass_done  = (pc_sum[16:0] >= pages_in_use);
    job_idx        = idx_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient      <= 5'd0;
      falling       <= 1'b0;
      busy_distance <= DIST_SAT;
      page_counter  <= 17'd0;
      idx           <= '0;
    end else if (accept) begin
      gradient      <= gradient_next;
      falling       <= falling_next;
      busy_distance <= busy_distance_next;
      page_counter  <= pc_sum[16:0];
      idx           <= idx_next;
    end
  end

endmodule

// ===== sv/pis_queue.sv =====
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module pis_queue #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         head_valid,
  output logic [W-1:0] head_data,
  input  logic         pop,
  output logic [$clog2(pis_pkg::QUEUE_DEPTH+1)-1:0] count
);
  import pis_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/pis_back.sv =====
// Back end: history memory, score arithmetic and the output register.
`timescale 1ns / 1ps
module pis_back #(
  parameter int unsigned IDX_W = 16,
  parameter int unsigned PAGES = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  pis_pkg::job_t    head_job,
  input  logic [IDX_W-1:0] head_idx,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      out_page_index,
  output logic [9:0]       out_score,
  output pis_pkg::status_t out_status,
  output logic [16:0]      out_next_page,
  output logic             out_pass_done
);
  import pis_pkg::*;

  logic [9:0]       hist_mem [PAGES];
  logic [IDX_W-1:0] clr_addr;

  // Stage 1: request with its history word just read.
  logic             s1_valid;
  job_t             s1_job;
  logic [IDX_W-1:0] s1_idx;
  logic [9:0]       rdata;
  logic             fwd;
  logic [9:0]       fwd_h;
  logic             s1_fire;

  logic [9:0]  h0, hb, q, hn, wdata;
  logic [11:0] x3;
  logic [27:0] prod;
  logic        scored;

  // Output stage: new history word, finished into the score after the register.
  logic [9:0]  out_hist;
  logic [4:0]  out_gradient;
  logic        out_huge;
  logic [9:0]  capped, sc;
  logic [10:0] sum;

  assign s1_fire = s1_valid && (!out_valid || out_ready);
  assign pop     = head_valid && !clearing && (!s1_valid || s1_fire);

  always_comb begin
    scored = (s1_job.status == ST_SCORED);
    h0     = fwd ? fwd_h : rdata;
    hb     = (s1_job.boost && h0 > BOOST_AMOUNT) ? h0 - BOOST_AMOUNT : h0;
    x3     = {1'b0, hb, 1'b0} + {2'b00, hb};
    prod   = x3 * DIV5_MUL;
    q      = prod[DIV5_SHIFT +: 10];
    hn     = q + (s1_job.idle ? IDLE_BONUS : 10'd0);
    wdata  = scored ? hn : 10'd0;
  end

  always_comb begin
    sum       = {1'b0, out_hist} + {6'd0, out_gradient};
    capped    = (sum >= {1'b0, SCORE_CAP}) ? SCORE_CAP : sum[9:0];
    sc        = (out_huge && capped >= HUGE_DISCOUNT) ? capped - HUGE_DISCOUNT : capped;
    out_score = (out_status == ST_SCORED) ? sc : 10'd0;
  end

  // Single write port (clear sweep or update), single registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      hist_mem[clr_addr] <= HIST_INIT;
    end else if (s1_fire) begin
      hist_mem[s1_idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= hist_mem[head_idx];
      fwd   <= s1_fire && (s1_idx == head_idx);
      fwd_h <= wdata;
      s1_job <= head_job;
      s1_idx <= head_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == IDX_W'(PAGES - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_page_index <= s1_job.page_index;
      out_hist       <= hn;
      out_gradient   <= s1_job.gradient;
      out_huge       <= s1_job.huge;
      out_status     <= s1_job.status;
      out_next_page  <= s1_job.next_page;
      out_pass_done  <= s1_job.pass_done;
    end
  end

endmodule
